FILE: hdl/ohl_pkg.sv
// ohl_pkg: shared types and constants for the ordered handle list
// operation codes, sequencer states and the result struct
// no dependencies
package ohl_pkg;

    localparam int KIND_W   = 4;
    localparam int POS_W    = 8;
    localparam int HANDLE_W = 16;
    localparam int COUNT_W  = 5;
    // wide enough to compare a position against any entry count
    localparam int CMP_W    = POS_W + 1;

    typedef enum logic [KIND_W-1:0] {
        OP_INSERT        = 4'd0,
        OP_GET           = 4'd1,
        OP_DELETE_AT     = 4'd2,
        OP_DELETE_HANDLE = 4'd3,
        OP_CLEAR         = 4'd4,
        OP_CURSOR_RESET  = 4'd5,
        OP_CURRENT       = 4'd6,
        OP_NEXT          = 4'd7,
        OP_PREV          = 4'd8,
        OP_LENGTH        = 4'd9
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_INS_SHIFT,
        S_INS_PUT,
        S_WALK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                valid;
        logic                ok;
        logic [HANDLE_W-1:0] handle;
        logic [COUNT_W-1:0]  count;
    } ohl_res_t;

endpackage

FILE: hdl/ohl_if.sv
// ohl_if: request and response channel interfaces for the handle list
// valid/ready handshake with the item payload
// depends on ohl_pkg
interface ohl_in_if;
    import ohl_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [POS_W-1:0]    position;
    logic [HANDLE_W-1:0] handle;

    modport source (output valid, output kind, output position, output handle, input ready);
    modport sink   (input valid, input kind, input position, input handle, output ready);
endinterface

interface ohl_out_if;
    import ohl_pkg::*;

    logic                valid;
    logic                ready;
    logic                ok;
    logic [HANDLE_W-1:0] handle_out;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output ok, output handle_out, output count, input ready);
    modport sink   (input valid, input ok, input handle_out, input count, output ready);
endinterface

FILE: hdl/ohl_ram.sv
// ohl_ram: generic single write port, single read port RAM
// read data is registered; no reset on contents
// no dependencies
module ohl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/ohl_seq.sv
// ohl_seq: sequencer for the handle list; walks the entry RAM one entry a cycle
// for insert shifts, delete shifts and handle search, and keeps count and cursor
// depends on ohl_pkg and ohl_if
module ohl_seq #(
    parameter int CAPACITY = 16,
    parameter int HW       = 16,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    ohl_in_if.sink           req,
    output ohl_pkg::ohl_res_t res,
    input  logic             res_ready,
    output logic             ram_we,
    output logic [AW-1:0]    ram_waddr,
    output logic [HW-1:0]    ram_wdata,
    output logic [AW-1:0]    ram_raddr,
    input  logic [HW-1:0]    ram_rdata
);
    import ohl_pkg::*;

    state_t            state_reg, state_next;
    op_t               kind_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [HW-1:0]     h_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     cur_reg, cur_next;
    logic              cur_valid_reg, cur_valid_next;
    logic [AW-1:0]     src_reg, src_next;
    logic [AW-1:0]     p_reg, p_next;
    logic              found_reg, found_next;
    logic              ok_reg, ok_next;
    logic [HW-1:0]     hout_reg, hout_next;

    logic              accept;
    logic              pos_in_range;
    logic [AW-1:0]     ins_p;
    logic [AW-1:0]     last_idx;
    logic [CW-1:0]     count_minus;
    logic [CW-1:0]     cur_inc;
    logic              cur_ok;
    logic              list_full;
    logic              hit;
    logic              walk_last;
    logic [AW-1:0]     del_p;

    assign accept = req.valid && req.ready;

    // shared compare and address terms
    assign pos_in_range = CMP_W'(pos_reg) < CMP_W'(count_reg);
    assign ins_p        = pos_in_range ? AW'(pos_reg) : AW'(count_reg);
    assign count_minus  = count_reg - CW'(1);
    assign last_idx     = AW'(count_minus);
    assign cur_inc      = CW'(cur_reg) + CW'(1);
    assign cur_ok       = cur_valid_reg && (CW'(cur_reg) < count_reg);
    assign list_full    = count_reg == CW'(CAPACITY);
    assign hit          = (kind_reg == OP_DELETE_HANDLE) ? (ram_rdata == h_reg) : 1'b1;
    assign walk_last    = src_reg == last_idx;
    assign del_p        = found_reg ? p_reg : src_reg;

    // next state, datapath control and ram access
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        src_next       = src_reg;
        p_next         = p_reg;
        found_next     = found_reg;
        ok_next        = ok_reg;
        hout_next      = hout_reg;
        ram_we         = 1'b0;
        ram_waddr      = src_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = src_reg;
        req.ready      = 1'b0;
        res.valid      = 1'b0;
        res.ok         = ok_reg;
        res.handle     = HANDLE_W'(hout_reg);
        res.count      = COUNT_W'(count_reg);

        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = S_START;
                end
            end

            S_START:
            begin
                ok_next    = 1'b0;
                hout_next  = '0;
                state_next = S_DONE;
                case (kind_reg)
                    OP_INSERT:
                    begin
                        if (h_reg != '0 && !list_full)
                        begin
                            ok_next = 1'b1;
                            p_next  = ins_p;
                            if (count_reg == '0)
                            begin
                                cur_next       = '0;
                                cur_valid_next = 1'b1;
                            end
                            else if (cur_valid_reg && cur_reg >= ins_p)
                            begin
                                cur_next = cur_reg + AW'(1);
                            end
                            // shift the tail up, last entry first
                            if (CW'(ins_p) < count_reg)
                            begin
                                ram_raddr  = last_idx;
                                src_next   = last_idx;
                                state_next = S_INS_SHIFT;
                            end
                            else
                            begin
                                state_next = S_INS_PUT;
                            end
                        end
                    end

                    OP_GET:
                    begin
                        if (pos_in_range)
                        begin
                            ok_next    = 1'b1;
                            ram_raddr  = AW'(pos_reg);
                            state_next = S_READ;
                        end
                    end

                    OP_DELETE_AT:
                    begin
                        if (pos_in_range)
                        begin
                            ram_raddr  = AW'(pos_reg);
                            src_next   = AW'(pos_reg);
                            found_next = 1'b0;
                            state_next = S_WALK;
                        end
                    end

                    OP_DELETE_HANDLE:
                    begin
                        if (count_reg != '0)
                        begin
                            ram_raddr  = '0;
                            src_next   = '0;
                            found_next = 1'b0;
                            state_next = S_WALK;
                        end
                    end

                    OP_CLEAR:
                    begin
                        ok_next        = 1'b1;
                        count_next     = '0;
                        cur_next       = '0;
                        cur_valid_next = 1'b0;
                    end

                    OP_CURSOR_RESET:
                    begin
                        cur_next       = '0;
                        cur_valid_next = count_reg != '0;
                        if (count_reg != '0)
                        begin
                            ok_next    = 1'b1;
                            ram_raddr  = '0;
                            state_next = S_READ;
                        end
                    end

                    OP_CURRENT:
                    begin
                        if (cur_ok)
                        begin
                            ok_next    = 1'b1;
                            ram_raddr  = cur_reg;
                            state_next = S_READ;
                        end
                    end

                    OP_NEXT:
                    begin
                        if (cur_ok)
                        begin
                            ok_next    = 1'b1;
                            ram_raddr  = cur_reg;
                            state_next = S_READ;
                            if (cur_inc >= count_reg)
                            begin
                                cur_valid_next = 1'b0;
                                cur_next       = '0;
                            end
                            else
                            begin
                                cur_next = cur_reg + AW'(1);
                            end
                        end
                    end

                    OP_PREV:
                    begin
                        if (cur_ok)
                        begin
                            ok_next    = 1'b1;
                            ram_raddr  = cur_reg;
                            state_next = S_READ;
                            if (cur_reg == '0)
                            begin
                                cur_valid_next = 1'b0;
                            end
                            else
                            begin
                                cur_next = cur_reg - AW'(1);
                            end
                        end
                    end

                    OP_LENGTH:
                    begin
                        ok_next = 1'b1;
                    end

                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end

            // single entry read for get and cursor operations
            S_READ:
            begin
                hout_next  = ram_rdata;
                state_next = S_DONE;
            end

            // move one entry up per cycle, overlapping read and write
            S_INS_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = src_reg + AW'(1);
                ram_wdata = ram_rdata;
                if (src_reg == p_reg)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    ram_raddr = src_reg - AW'(1);
                    src_next  = src_reg - AW'(1);
                end
            end

            S_INS_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = p_reg;
                ram_wdata  = h_reg;
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end

            // search for the entry, then close the gap one entry per cycle
            S_WALK:
            begin
                if (!found_reg)
                begin
                    if (hit)
                    begin
                        found_next = 1'b1;
                        p_next     = src_reg;
                        hout_next  = ram_rdata;
                    end
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = src_reg - AW'(1);
                    ram_wdata = ram_rdata;
                end

                if (walk_last)
                begin
                    state_next = S_DONE;
                    if (found_reg || hit)
                    begin
                        ok_next    = 1'b1;
                        count_next = count_minus;
                        if (cur_valid_reg)
                        begin
                            if (cur_reg == del_p)
                            begin
                                if (CW'(del_p) >= count_minus)
                                begin
                                    cur_valid_next = 1'b0;
                                end
                            end
                            else if (cur_reg > del_p)
                            begin
                                cur_next = cur_reg - AW'(1);
                            end
                        end
                    end
                    else
                    begin
                        ok_next   = 1'b0;
                        hout_next = '0;
                    end
                end
                else
                begin
                    ram_raddr = src_reg + AW'(1);
                    src_next  = src_reg + AW'(1);
                end
            end

            S_DONE:
            begin
                res.valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            cur_valid_reg <= cur_valid_next;
        end
    end

    // item payload and walk registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= op_t'(req.kind);
            pos_reg  <= req.position;
            h_reg    <= req.handle[HW-1:0];
        end
        src_reg   <= src_next;
        p_reg     <= p_next;
        found_reg <= found_next;
        ok_reg    <= ok_next;
        hout_reg  <= hout_next;
    end

`ifndef SYNTH
    // the cursor moves ahead of the count during an insert, so check between items
    a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && cur_valid_reg) |-> (CW'(cur_reg) < count_reg))
        else $error("cursor points past the last entry");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_START))
        else $error("accepted item did not start");

    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !res_ready) |=> (state_reg == S_DONE && $stable(count_reg)))
        else $error("result dropped while stalled");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !ram_we)
        else $error("entry ram written outside an operation");
`endif

endmodule

FILE: hdl/ordered_handle_list_with_cursor_top.sv
// ordered_handle_list_with_cursor_top: ordered handle list with cursor
// instantiates the sequencer, the entry RAM and the response register
// depends on ohl_pkg, ohl_if, ohl_ram and ohl_seq
//
// Usage:
//   req carries one operation per item (kind, position, handle); rsp returns
//   exactly one item per request (ok, handle_out, count), in order.
//   req.ready is high only while the sequencer is idle. Clear, length and
//   unused codes need no RAM access, get and cursor operations read one
//   entry, insert moves each entry from the position to the end up by one,
//   delete at walks from the position to the end and delete by handle walks
//   the whole list: the RAM walk moves one entry per cycle. The next request
//   is accepted in the cycle after the response leaves the sequencer.
//   A response register sits between the sequencer and rsp, so a new request
//   is accepted while the previous response still waits. When rsp stalls
//   with the register full, the next finished response waits in the
//   sequencer and req.ready stays low.
//   Reset empties the list and leaves the cursor nowhere; the RAM contents
//   are not cleared and need no clearing pass.
module ordered_handle_list_with_cursor_top #(
    parameter int CAPACITY    = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    ohl_in_if.sink   req,
    ohl_out_if.source rsp
);
    import ohl_pkg::*;

    localparam int HW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    ohl_res_t              res;
    logic                  res_ready;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [HW-1:0]         ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [HW-1:0]         ram_rdata;

    logic                  out_valid_reg;
    logic                  out_ok_reg;
    logic [HANDLE_W-1:0]   out_handle_reg;
    logic [COUNT_W-1:0]    out_count_reg;

    ohl_seq #(
        .CAPACITY (CAPACITY),
        .HW       (HW),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res       (res),
        .res_ready (res_ready),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    ohl_ram #(
        .WIDTH (HW),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // response register loads when empty or being drained
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res.valid)
        begin
            out_ok_reg     <= res.ok;
            out_handle_reg <= res.handle;
            out_count_reg  <= res.count;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.ok         = out_ok_reg;
    assign rsp.handle_out = out_handle_reg;
    assign rsp.count      = out_count_reg;

endmodule

FILE: sim/tb_ordered_handle_list_with_cursor_top.sv
// tb_ordered_handle_list_with_cursor_top: self-checking bench for the ordered handle list
// directed cursor and range cases, then random traffic under several idle and stall mixes
// depends on ohl_pkg, ohl_if and ordered_handle_list_with_cursor_top
`timescale 1ns / 100ps

module tb_ordered_handle_list_with_cursor_top;
    import ohl_pkg::*;

    localparam int CAP   = 16;
    localparam int HBITS = 16;
    localparam logic [HANDLE_W-1:0] HANDLE_MASK = {HANDLE_W{1'b1}} >> (HANDLE_W - HBITS);
    // highest code that the block ignores
    localparam logic [KIND_W-1:0] KIND_UNUSED_MAX = 4'd15;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic                ok;
        logic [HANDLE_W-1:0] handle;
        logic [COUNT_W-1:0]  count;
    } list_result_t;

    logic clk;
    logic rst_n;

    ohl_in_if  req_if ();
    ohl_out_if rsp_if ();

    ordered_handle_list_with_cursor_top #(
        .CAPACITY    (CAP),
        .HANDLE_BITS (HBITS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // shadow copy of the list and cursor
    logic [HANDLE_W-1:0] list_mem [CAP];
    int                  list_len;
    int                  cur_pos;
    bit                  cur_on;

    list_result_t        pending_q [$];
    int                  fail_count;
    int                  send_idle_pct;
    int                  recv_stall_pct;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("tb_ordered_handle_list_with_cursor_top: FAIL");
        $finish;
    end

    // remove one entry and keep the cursor on its entry or the successor, or turn it off if none
    function automatic void list_remove(input int p);
        for (int i = p; i + 1 < list_len; i++)
            list_mem[i] = list_mem[i + 1];
        list_len--;
        if (cur_on)
        begin
            if (cur_pos == p)
            begin
                if (p >= list_len)
                    cur_on = 1'b0;
            end
            else if (cur_pos > p)
            begin
                cur_pos--;
            end
        end
    endfunction

    // apply one operation to the shadow list and return the expected response
    function automatic list_result_t list_apply(input logic [KIND_W-1:0] kind,
                                                input logic [POS_W-1:0] position,
                                                input logic [HANDLE_W-1:0] handle);
        list_result_t        r;
        int                  p;
        logic [HANDLE_W-1:0] h;
        bit                  hit;
        r.ok     = 1'b0;
        r.handle = '0;
        p        = int'(position);
        h        = handle & HANDLE_MASK;
        hit      = 1'b0;
        case (kind)
            OP_INSERT:
            begin
                if (h != '0 && list_len < CAP)
                begin
                    if (p > list_len)
                        p = list_len;
                    for (int i = list_len; i > p; i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[p] = h;
                    if (list_len == 0)
                    begin
                        cur_pos = 0;
                        cur_on  = 1'b1;
                    end
                    else if (cur_on && cur_pos >= p)
                    begin
                        cur_pos++;
                    end
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            OP_GET:
            begin
                if (p < list_len)
                begin
                    r.ok     = 1'b1;
                    r.handle = list_mem[p];
                end
            end
            OP_DELETE_AT:
            begin
                if (p < list_len)
                begin
                    r.ok     = 1'b1;
                    r.handle = list_mem[p];
                    list_remove(p);
                end
            end
            OP_DELETE_HANDLE:
            begin
                for (int i = 0; i < list_len && !hit; i++)
                begin
                    if (list_mem[i] == h)
                    begin
                        hit      = 1'b1;
                        r.ok     = 1'b1;
                        r.handle = list_mem[i];
                        list_remove(i);
                    end
                end
            end
            OP_CLEAR:
            begin
                list_len = 0;
                cur_pos  = 0;
                cur_on   = 1'b0;
                r.ok     = 1'b1;
            end
            OP_CURSOR_RESET:
            begin
                cur_pos = 0;
                cur_on  = (list_len > 0);
                if (cur_on)
                begin
                    r.ok     = 1'b1;
                    r.handle = list_mem[0];
                end
            end
            OP_CURRENT:
            begin
                if (cur_on && cur_pos < list_len)
                begin
                    r.ok     = 1'b1;
                    r.handle = list_mem[cur_pos];
                end
            end
            OP_NEXT:
            begin
                if (cur_on && cur_pos < list_len)
                begin
                    r.ok     = 1'b1;
                    r.handle = list_mem[cur_pos];
                    cur_pos++;
                    if (cur_pos >= list_len)
                    begin
                        cur_on  = 1'b0;
                        cur_pos = 0;
                    end
                end
            end
            OP_PREV:
            begin
                if (cur_on && cur_pos < list_len)
                begin
                    r.ok     = 1'b1;
                    r.handle = list_mem[cur_pos];
                    if (cur_pos == 0)
                        cur_on = 1'b0;
                    else
                        cur_pos--;
                end
            end
            OP_LENGTH:
            begin
                r.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.count = list_len[COUNT_W-1:0];
        return r;
    endfunction

    // response side: random backpressure
    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compare each response item with the oldest expected one
    always @(posedge clk)
    begin : check_results
        list_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_q.size() == 0)
            begin
                $error("unexpected response item: ok %0d handle_out %h count %0d",
                       rsp_if.ok, rsp_if.handle_out, rsp_if.count);
                fail_count++;
            end
            else
            begin
                want = pending_q.pop_front();
                if (rsp_if.ok !== want.ok)
                begin
                    $error("ok: expected %0d, actual %0d", want.ok, rsp_if.ok);
                    fail_count++;
                end
                if (rsp_if.handle_out !== want.handle)
                begin
                    $error("handle_out: expected %h, actual %h", want.handle, rsp_if.handle_out);
                    fail_count++;
                end
                if (rsp_if.count !== want.count)
                begin
                    $error("count: expected %0d, actual %0d", want.count, rsp_if.count);
                    fail_count++;
                end
            end
        end
    end

    // drive one request item, wait for the handshake, then maybe idle
    task automatic send_item(input logic [KIND_W-1:0] kind,
                             input logic [POS_W-1:0] position,
                             input logic [HANDLE_W-1:0] handle);
        req_if.valid    <= 1'b1;
        req_if.kind     <= kind;
        req_if.position <= position;
        req_if.handle   <= handle;
        do
            @(posedge clk);
        while (!req_if.ready);
        pending_q.push_back(list_apply(kind, position, handle));
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
    endtask

    // hold off until every expected response has arrived
    task automatic wait_responses;
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // one random item shaped by the current list contents
    task automatic send_random_item(output bit counted);
        int                  r;
        logic [KIND_W-1:0]   k;
        logic [POS_W-1:0]    p;
        logic [HANDLE_W-1:0] h;
        r = $urandom_range(99);
        if ($urandom_range(99) < 70)
            p = POS_W'($urandom_range(list_len, 0));
        else
            p = POS_W'($urandom_range(255, 0));
        h = HANDLE_W'($urandom_range(16'hFFFF, 1));
        if (r < 40)
        begin
            k = OP_INSERT;
            if ($urandom_range(99) < 4)
                h = '0;
            else if (list_len > 0 && $urandom_range(99) < 4)
                h = list_mem[$urandom_range(list_len - 1, 0)];
        end
        else if (r < 50)
            k = OP_GET;
        else if (r < 58)
            k = OP_DELETE_AT;
        else if (r < 68)
        begin
            k = OP_DELETE_HANDLE;
            if (list_len > 0 && $urandom_range(99) < 80)
                h = list_mem[$urandom_range(list_len - 1, 0)];
            else if ($urandom_range(99) < 20)
                h = '0;
        end
        else if (r < 70)
            k = OP_CLEAR;
        else if (r < 75)
            k = OP_CURSOR_RESET;
        else if (r < 80)
            k = OP_CURRENT;
        else if (r < 87)
            k = OP_NEXT;
        else if (r < 94)
            k = OP_PREV;
        else if (r < 97)
            k = OP_LENGTH;
        else
            k = KIND_W'($urandom_range(KIND_UNUSED_MAX, OP_LENGTH + 1));
        counted = (k <= OP_LENGTH);
        send_item(k, p, h);
    endtask

    // the read, cursor, delete and length operations on an empty list, plus an unused code
    task automatic test_empty_list;
        send_item(OP_GET, 8'd0, 16'h0000);
        send_item(OP_CURRENT, 8'd0, 16'h0000);
        send_item(OP_CURSOR_RESET, 8'd0, 16'h0000);
        send_item(OP_NEXT, 8'd0, 16'h0000);
        send_item(OP_PREV, 8'd0, 16'h0000);
        send_item(OP_DELETE_AT, 8'd0, 16'h0000);
        send_item(OP_DELETE_HANDLE, 8'd0, 16'h0000);
        send_item(OP_LENGTH, 8'd0, 16'h0000);
        send_item(KIND_UNUSED_MAX, 8'hFF, 16'hFFFF);
    endtask

    // insert rules and cursor moves from the head
    task automatic test_insert_cursor;
        // zero handle is rejected
        send_item(OP_INSERT, 8'd0, 16'h0000);
        // empty list: appends and sets the cursor
        send_item(OP_INSERT, 8'hFF, 16'hFFFF);
        // insert before cursor shifts its position
        send_item(OP_INSERT, 8'd0, 16'h0001);
        send_item(OP_INSERT, 8'd200, 16'hA5A5);
        send_item(OP_CURRENT, 8'd0, 16'h0000);
        send_item(OP_PREV, 8'd0, 16'h0000);
        // prev from head leaves the cursor nowhere
        send_item(OP_PREV, 8'd0, 16'h0000);
        send_item(OP_CURRENT, 8'd0, 16'h0000);
        send_item(OP_GET, 8'd2, 16'h0000);
        send_item(OP_GET, 8'hFF, 16'h0000);
    endtask

    // deletes under and before the cursor, past the end and of an absent handle
    task automatic test_delete_cursor;
        send_item(OP_CURSOR_RESET, 8'd0, 16'h0000);
        send_item(OP_NEXT, 8'd0, 16'h0000);
        send_item(OP_DELETE_AT, 8'hFF, 16'h0000);
        send_item(OP_DELETE_AT, 8'd1, 16'h0000);
        send_item(OP_CURRENT, 8'd0, 16'h0000);
        send_item(OP_DELETE_AT, 8'd0, 16'h0000);
        send_item(OP_DELETE_HANDLE, 8'd0, 16'h1234);
        // under the cursor with no successor
        send_item(OP_DELETE_HANDLE, 8'd0, 16'hA5A5);
        send_item(OP_INSERT, 8'd0, 16'h5A5A);
        // next from the last entry
        send_item(OP_NEXT, 8'd0, 16'h0000);
        send_item(OP_CLEAR, 8'd0, 16'h0000);
    endtask

    // random traffic; pauses once halfway until all responses are in
    task automatic test_random(input int n_items, input int send_pct, input int recv_pct);
        int sent;
        bit counted;
        sent = 0;
        set_idling(send_pct, recv_pct);
        while (sent < n_items)
        begin
            send_random_item(counted);
            if (counted)
            begin
                sent++;
                if (sent == n_items / 2)
                begin
                    req_if.valid <= 1'b0;
                    wait_responses();
                end
            end
        end
    endtask

    // main sequence
    initial
    begin
        rst_n           = 1'b0;
        req_if.valid    = 1'b0;
        req_if.kind     = '0;
        req_if.position = '0;
        req_if.handle   = '0;
        list_len        = 0;
        cur_pos         = 0;
        cur_on          = 1'b0;
        fail_count      = 0;
        set_idling(0, 0);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_insert_cursor();
        test_delete_cursor();
        test_random(280, 0, 0);
        test_random(270, 76, 0);
        test_random(270, 0, 76);
        test_random(280, 22, 22);

        req_if.valid <= 1'b0;
        wait_responses();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_ordered_handle_list_with_cursor_top: PASS");
        else
            $display("tb_ordered_handle_list_with_cursor_top: FAIL");
        $finish;
    end

endmodule
